### rtl/core/stp_pkg.sv
// Package for the version tag parser: character codes, parser phases,
// parser state record and the per-byte update function. No dependencies.
package stp_pkg;

    localparam int PRERELEASE_BYTES = 32;
    localparam logic [5:0] SUFFIX_MAX = 6'(PRERELEASE_BYTES - 1);

    localparam logic [19:0] FIELD_LIMIT = 20'd65535;
    localparam logic [16:0] ACC_SAT = 17'd65536;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_V = 8'h76;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_R = 8'h72;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [1:0] CH_STABLE = 2'd0;
    localparam logic [1:0] CH_RC = 2'd1;
    localparam logic [1:0] CH_DEV = 2'd2;

    typedef enum logic [5:0] {
        PH_START        = 6'b000001,
        PH_MAJOR        = 6'b000010,
        PH_MINOR        = 6'b000100,
        PH_PATCH        = 6'b001000,
        PH_SUFFIX_FIRST = 6'b010000,
        PH_SUFFIX       = 6'b100000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        field_prefix;
        logic        negative_sign;
        logic        digits_seen;
        logic [16:0] accumulator;
        logic [15:0] major_store;
        logic [15:0] minor_store;
        logic [5:0]  suffix_count;
        logic        previous_was_r;
        logic        rc_seen;
        logic        error_flag;
        logic        string_ended;
    } parse_t;

    localparam parse_t PARSE_RESET = '{PH_START, 1'b0, 1'b0, 1'b0, 17'd0, 16'd0, 16'd0,
                                       6'd0, 1'b0, 1'b0, 1'b0, 1'b0};

    function automatic parse_t field_byte(parse_t s, logic [7:0] c);
        parse_t      r;
        logic        digit;
        logic        space;
        logic [19:0] v;
        r = s;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        v = {s.accumulator, 3'b000} + {2'b00, s.accumulator, 1'b0} + {12'd0, c - CHAR_ZERO};
        if (digit) begin
            r.accumulator = (v > FIELD_LIMIT) ? ACC_SAT : v[16:0];
            r.digits_seen = 1'b1;
        end else if (!s.digits_seen) begin
            if (!s.field_prefix && space) begin
                r = s;
            end else if (!s.field_prefix && (c == CHAR_PLUS || c == CHAR_DASH)) begin
                r.field_prefix = 1'b1;
                r.negative_sign = (c == CHAR_DASH);
            end else begin
                r.error_flag = 1'b1;
            end
        end else if (s.accumulator[16] || (s.negative_sign && s.accumulator != 17'd0)) begin
            r.error_flag = 1'b1;
        end else if (s.phase == PH_MAJOR || s.phase == PH_MINOR) begin
            if (c != CHAR_DOT) begin
                r.error_flag = 1'b1;
            end else begin
                if (s.phase == PH_MAJOR) begin
                    r.major_store = s.accumulator[15:0];
                    r.phase = PH_MINOR;
                end else begin
                    r.minor_store = s.accumulator[15:0];
                    r.phase = PH_PATCH;
                end
                r.field_prefix = 1'b0;
                r.negative_sign = 1'b0;
                r.digits_seen = 1'b0;
                r.accumulator = 17'd0;
            end
        end else if (c == CHAR_DASH) begin
            r.phase = PH_SUFFIX_FIRST;
        end else if (c != CHAR_NUL) begin
            r.error_flag = 1'b1;
        end
        return r;
    endfunction

    function automatic parse_t take_byte(parse_t s, logic [7:0] c);
        parse_t r;
        parse_t t;
        r = s;
        t = s;
        if (!s.error_flag && !s.string_ended) begin
            t.string_ended = (c == CHAR_NUL);
            r = t;
            case (s.phase)
                PH_START: begin
                    t.phase = PH_MAJOR;
                    r = (c == CHAR_V) ? t : field_byte(t, c);
                end
                PH_MAJOR, PH_MINOR, PH_PATCH: begin
                    r = field_byte(t, c);
                end
                PH_SUFFIX_FIRST: begin
                    if (c == CHAR_NUL) begin
                        r.error_flag = 1'b1;
                    end else begin
                        r.suffix_count = 6'd1;
                        r.previous_was_r = (c == CHAR_R);
                        r.phase = PH_SUFFIX;
                    end
                end
                PH_SUFFIX: begin
                    if (c == CHAR_NUL) begin
                        r = t;
                    end else if (s.suffix_count >= SUFFIX_MAX) begin
                        r.error_flag = 1'b1;
                    end else begin
                        r.suffix_count = s.suffix_count + 6'd1;
                        if (s.previous_was_r && c == CHAR_C) begin
                            r.rc_seen = 1'b1;
                        end
                        r.previous_was_r = (c == CHAR_R);
                    end
                end
                default: begin
                    r.error_flag = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/core/semver_tag_parser.sv
// Throughput one request per cycle while no finished result is left waiting on m_ready.
// Stage 1 registers the byte, stage 2 updates the parser state and loads the result register.
// A non-final byte waits in stage 1 only while a finished result is not taken.
// Reset (synchronous, aresetn low) returns the parser to the start of a tag, drops all requests.
// Version tag parser top level; depends on stp_pkg.
module semver_tag_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [15:0] m_major_number,
    output logic [15:0] m_minor_number,
    output logic [15:0] m_patch_number,
    output logic        m_has_prerelease,
    output logic [4:0]  m_prerelease_length,
    output logic [1:0]  m_channel
);
    import stp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    parse_t      parse_reg;
    parse_t      parse_next;
    parse_t      step_one;
    parse_t      step_two;
    logic        out_valid_reg;
    logic        valid_res_reg;
    logic [15:0] major_reg;
    logic [15:0] minor_reg;
    logic [15:0] patch_reg;
    logic        has_pre_reg;
    logic [4:0]  pre_len_reg;
    logic [1:0]  channel_reg;
    logic        advance;
    logic        fire;
    logic        ok;
    logic        pre;

    assign advance = !out_valid_reg || m_ready;
    assign fire = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        step_one = take_byte(parse_reg, char_reg);
        step_two = take_byte(step_one, CHAR_NUL);
        ok = !step_two.error_flag && step_two.string_ended;
        pre = ok && (step_two.phase == PH_SUFFIX);
        parse_next = parse_reg;
        if (fire) begin
            parse_next = last_reg ? PARSE_RESET : step_one;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            parse_reg <= PARSE_RESET;
        end else begin
            parse_reg <= parse_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= fire && last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_character;
            last_reg <= s_last;
        end
        if (fire && last_reg) begin
            valid_res_reg <= ok;
            major_reg <= ok ? step_two.major_store : 16'd0;
            minor_reg <= ok ? step_two.minor_store : 16'd0;
            patch_reg <= ok ? step_two.accumulator[15:0] : 16'd0;
            has_pre_reg <= pre;
            pre_len_reg <= pre ? step_two.suffix_count[4:0] : 5'd0;
            channel_reg <= pre ? (step_two.rc_seen ? CH_RC : CH_DEV) : CH_STABLE;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_valid_res = valid_res_reg;
    assign m_major_number = major_reg;
    assign m_minor_number = minor_reg;
    assign m_patch_number = patch_reg;
    assign m_has_prerelease = has_pre_reg;
    assign m_prerelease_length = pre_len_reg;
    assign m_channel = channel_reg;

endmodule

### verif/version_result_checker.sv
// Watches both channels of the version tag parser, predicts each result from the
// accepted bytes and compares it field by field. Depends on stp_pkg.
module version_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_valid_res,
    input  logic [15:0] m_major_number,
    input  logic [15:0] m_minor_number,
    input  logic [15:0] m_patch_number,
    input  logic        m_has_prerelease,
    input  logic [4:0]  m_prerelease_length,
    input  logic [1:0]  m_channel,
    output int unsigned mismatch_count,
    output int unsigned results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import stp_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [15:0] major_v;
        logic [15:0] minor_v;
        logic [15:0] patch_v;
        logic        has_pre;
        logic [4:0]  pre_len;
        logic [1:0]  chan;
    } tag_result_t;

    phase_t      stage;
    logic        sign_done;
    logic        minus;
    logic        have_digits;
    logic [16:0] acc;
    logic [15:0] major_q;
    logic [15:0] minor_q;
    logic [5:0]  suffix_len;
    logic        after_r;
    logic        rc_found;
    logic        bad;
    logic        ended;
    int unsigned fails;
    tag_result_t owed_q[$];

    function automatic void clear_number();
        sign_done = 1'b0;
        minus = 1'b0;
        have_digits = 1'b0;
        acc = '0;
    endfunction

    function automatic void restart_tag();
        stage = PH_START;
        clear_number();
        major_q = '0;
        minor_q = '0;
        suffix_len = '0;
        after_r = 1'b0;
        rc_found = 1'b0;
        bad = 1'b0;
        ended = 1'b0;
    endfunction

    function automatic void number_char(logic [7:0] c);
        int unsigned grown;
        logic        blank;
        blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            grown = acc * 10 + (c - CHAR_ZERO);
            acc = (grown > FIELD_LIMIT) ? ACC_SAT : 17'(grown);
            have_digits = 1'b1;
        end else if (!have_digits) begin
            if (sign_done || !blank) begin
                if (!sign_done && (c == CHAR_PLUS || c == CHAR_DASH)) begin
                    sign_done = 1'b1;
                    minus = (c == CHAR_DASH);
                end else begin
                    bad = 1'b1;
                end
            end
        end else if (acc > FIELD_LIMIT || (minus && acc != 0)) begin
            bad = 1'b1;
        end else if (stage == PH_MAJOR || stage == PH_MINOR) begin
            if (c != CHAR_DOT) begin
                bad = 1'b1;
            end else begin
                if (stage == PH_MAJOR) begin
                    major_q = acc[15:0];
                    stage = PH_MINOR;
                end else begin
                    minor_q = acc[15:0];
                    stage = PH_PATCH;
                end
                clear_number();
            end
        end else if (c == CHAR_DASH) begin
            stage = PH_SUFFIX_FIRST;
        end else if (c != CHAR_NUL) begin
            bad = 1'b1;
        end
    endfunction

    function automatic void absorb(logic [7:0] c);
        if (bad || ended) return;
        if (c == CHAR_NUL) ended = 1'b1;
        case (stage)
            PH_START: begin
                stage = PH_MAJOR;
                if (c != CHAR_V) number_char(c);
            end
            PH_MAJOR, PH_MINOR, PH_PATCH: begin
                number_char(c);
            end
            PH_SUFFIX_FIRST: begin
                if (c == CHAR_NUL) begin
                    bad = 1'b1;
                end else begin
                    suffix_len = 6'd1;
                    after_r = (c == CHAR_R);
                    stage = PH_SUFFIX;
                end
            end
            PH_SUFFIX: begin
                if (c != CHAR_NUL) begin
                    if (suffix_len >= SUFFIX_MAX) begin
                        bad = 1'b1;
                    end else begin
                        suffix_len = suffix_len + 6'd1;
                        if (after_r && c == CHAR_C) rc_found = 1'b1;
                        after_r = (c == CHAR_R);
                    end
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        tag_result_t want;
        if (!aresetn) begin
            restart_tag();
            owed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: result with no request waiting", $time);
                    fails++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("valid_res", want.ok, m_valid_res);
                    check_field("major_number", want.major_v, m_major_number);
                    check_field("minor_number", want.minor_v, m_minor_number);
                    check_field("patch_number", want.patch_v, m_patch_number);
                    check_field("has_prerelease", want.has_pre, m_has_prerelease);
                    check_field("prerelease_length", want.pre_len, m_prerelease_length);
                    check_field("channel", want.chan, m_channel);
                end
            end
            if (s_valid && s_ready) begin
                absorb(s_character);
                if (s_last) begin
                    absorb(CHAR_NUL);
                    want.ok = !bad && ended;
                    want.major_v = want.ok ? major_q : '0;
                    want.minor_v = want.ok ? minor_q : '0;
                    want.patch_v = want.ok ? acc[15:0] : '0;
                    want.has_pre = want.ok && stage == PH_SUFFIX;
                    want.pre_len = want.has_pre ? suffix_len[4:0] : '0;
                    want.chan = !want.has_pre ? CH_STABLE : (rc_found ? CH_RC : CH_DEV);
                    owed_q.push_back(want);
                    restart_tag();
                end
            end
        end
        mismatch_count <= fails;
        results_owed <= owed_q.size();
    end

endmodule

### verif/testbench.sv
// Top of the version tag parser testbench: clock, reset, tag stimulus and receiver
// stalls, verdict. Depends on stp_pkg, semver_tag_parser and version_result_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import stp_pkg::*;

    localparam int unsigned TARGET_BYTES = 1950;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic [15:0] m_major_number;
    logic [15:0] m_minor_number;
    logic [15:0] m_patch_number;
    logic        m_has_prerelease;
    logic [4:0]  m_prerelease_length;
    logic [1:0]  m_channel;

    int unsigned mismatch_count;
    int unsigned results_owed;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    logic [7:0]  tag_q[$];
    bit          sender_calm = 1'b0;
    bit          hold_off_request = 1'b0;
    bit          hold_done = 1'b0;
    bit          rx_calm = 1'b0;

    always #4 aclk = ~aclk;

    semver_tag_parser dut (.*);

    version_result_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic put_text(string t);
        for (int i = 0; i < t.len(); i++) tag_q.push_back(t[i]);
    endtask

    task automatic put_number();
        int unsigned v;
        int unsigned sign_pick;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                tag_q.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                                     : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
            end
        end
        sign_pick = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
            0:       v = 0;
            1, 2, 3: v = $urandom_range(0, 99);
            4:       v = $urandom_range(0, 9);
            5:       v = $urandom_range(0, 65535);
            6:       v = $urandom_range(65530, 65540);
            default: v = $urandom_range(65536, 9999999);
        endcase
        if (sign_pick == 9) begin
            tag_q.push_back(CHAR_DASH);
            if ($urandom_range(0, 2) != 0) v = 0;
        end else if (sign_pick >= 7) begin
            tag_q.push_back(CHAR_PLUS);
        end
        if ($urandom_range(0, 7) == 0) tag_q.push_back(CHAR_ZERO);
        put_text($sformatf("%0d", v));
    endtask

    task automatic build_version();
        int unsigned r;
        int unsigned len;
        if ($urandom_range(0, 1)) tag_q.push_back(CHAR_V);
        put_number();
        tag_q.push_back(CHAR_DOT);
        put_number();
        tag_q.push_back(CHAR_DOT);
        put_number();
        if ($urandom_range(0, 1)) begin
            tag_q.push_back(CHAR_DASH);
            r = $urandom_range(0, 99);
            if (r < 5) len = 0;
            else if (r < 88) len = $urandom_range(1, 8);
            else len = $urandom_range(PRERELEASE_BYTES - 3, PRERELEASE_BYTES + 1);
            repeat (len) begin
                case ($urandom_range(0, 5))
                    0:       tag_q.push_back(CHAR_R);
                    1:       tag_q.push_back(CHAR_C);
                    2, 3:    tag_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    default: tag_q.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end
        if ($urandom_range(0, 1)) begin
            tag_q.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 2)) tag_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_tag();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            build_version();
        end else if (r < 88) begin
            build_version();
            tag_q[$urandom_range(0, tag_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
            repeat ($urandom_range(1, 6)) tag_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_tag();
        int unsigned gap;
        for (int i = 0; i < tag_q.size(); i++) begin
            s_valid <= 1'b1;
            s_character <= tag_q[i];
            s_last <= (i == tag_q.size() - 1);
            do @(posedge aclk); while (!s_ready);
            bytes_sent++;
            gap = sender_calm ? 0 : idle_gap();
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        tag_q.delete();
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    initial begin : receiver
        int unsigned wait_left;
        int unsigned stretch;
        wait_left = 0;
        stretch = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (wait_left > 0) begin
                m_ready <= 1'b0;
                wait_left--;
            end else begin
                m_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) wait_left = idle_gap();
            end
            if (stretch == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(50, 400);
            end else begin
                stretch--;
            end
        end
    end

    initial begin : stimulus
        bit paused;
        paused = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_text("v0.0.0-rc");
        send_tag();
        put_text("\t-0.+65535.9-");
        tag_q.push_back(8'hFF);
        tag_q.push_back(CHAR_NUL);
        tag_q.push_back(8'h01);
        send_tag();
        put_text("+ 1");
        send_tag();
        put_text("1.2.3-");
        send_tag();
        put_text("99999");
        send_tag();
        drain_results();

        hold_off_request <= 1'b1;
        while (bytes_sent < TARGET_BYTES) begin
            if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
            if (!paused && bytes_sent > TARGET_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
            build_tag();
            send_tag();
        end
        drain_results();
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
